// ----- rtl/core/tpma_pkg.sv -----
// tpma_pkg: phase codes, hold-register update codes and the control struct
// shared by the two-port memory access arbiter top level and its phase decoder
// no dependencies
package tpma_pkg;

    localparam int PHASE_W = 4;

    typedef logic [PHASE_W-1:0] phase_t;

    // arbiter phases
    localparam phase_t PH_IDLE = 4'd0;
    localparam phase_t PH_DEV0 = 4'd1;
    localparam phase_t PH_WR0  = 4'd2;
    localparam phase_t PH_END0 = 4'd3;
    localparam phase_t PH_RD0  = 4'd4;
    localparam phase_t PH_GET0 = 4'd5;
    localparam phase_t PH_DEV1 = 4'd6;
    localparam phase_t PH_WR1  = 4'd7;
    localparam phase_t PH_END1 = 4'd8;
    localparam phase_t PH_RD1  = 4'd9;
    localparam phase_t PH_GET1 = 4'd10;

    typedef logic [1:0] hold_op_t;

    // update codes for the address and write data hold registers
    localparam hold_op_t HOLD_KEEP = 2'd0;
    localparam hold_op_t HOLD_ZERO = 2'd1;
    localparam hold_op_t HOLD_REQ0 = 2'd2;
    localparam hold_op_t HOLD_REQ1 = 2'd3;

    typedef struct packed {
        logic     mem_write;
        logic     mem_read;
        logic     ack0;
        logic     ack1;
        hold_op_t addr_op;
        hold_op_t wdata_op;
        logic     rdata0_load;
        logic     rdata1_load;
    } tpma_ctl_t;

endpackage

// ----- rtl/core/tpma_fsm.sv -----
// tpma_fsm: next-phase logic and per-phase control decode of the arbiter
// depends on tpma_pkg
module tpma_fsm (
    input  tpma_pkg::phase_t    phase,
    input  logic                req0,
    input  logic                req1,
    input  logic                is_write0,
    input  logic                is_write1,
    input  logic                mem_ready,
    output tpma_pkg::phase_t    phase_next,
    output tpma_pkg::tpma_ctl_t ctl
);
    import tpma_pkg::*;

    // next phase, unused codes behave as idle
    always_comb begin
        case (phase)
            PH_DEV0: phase_next = is_write0 ? PH_WR0 : PH_RD0;
            PH_WR0:  phase_next = mem_ready ? PH_END0 : PH_WR0;
            PH_RD0:  phase_next = mem_ready ? PH_GET0 : PH_RD0;
            PH_END0,
            PH_GET0: phase_next = req1 ? PH_DEV1 : PH_IDLE;
            PH_DEV1: phase_next = is_write1 ? PH_WR1 : PH_RD1;
            PH_WR1:  phase_next = mem_ready ? PH_END1 : PH_WR1;
            PH_RD1:  phase_next = mem_ready ? PH_GET1 : PH_RD1;
            PH_END1,
            PH_GET1: phase_next = req0 ? PH_DEV0 : PH_IDLE;
            default: phase_next = req0 ? PH_DEV0 : (req1 ? PH_DEV1 : PH_IDLE);
        endcase
    end

    // controls follow the phase reached
    always_comb begin
        ctl = '0;
        ctl.addr_op  = HOLD_KEEP;
        ctl.wdata_op = HOLD_KEEP;
        case (phase_next)
            PH_DEV0: begin
                ctl.addr_op  = HOLD_REQ0;
                ctl.wdata_op = HOLD_ZERO;
            end
            PH_WR0: begin
                ctl.mem_write = 1'b1;
                ctl.wdata_op  = HOLD_REQ0;
            end
            PH_END0: ctl.ack0 = 1'b1;
            PH_RD0:  ctl.mem_read = 1'b1;
            PH_GET0: begin
                ctl.ack0        = 1'b1;
                ctl.rdata0_load = 1'b1;
            end
            PH_DEV1: begin
                ctl.addr_op  = HOLD_REQ1;
                ctl.wdata_op = HOLD_ZERO;
            end
            PH_WR1: begin
                ctl.mem_write = 1'b1;
                ctl.wdata_op  = HOLD_REQ1;
            end
            PH_END1: ctl.ack1 = 1'b1;
            PH_RD1:  ctl.mem_read = 1'b1;
            PH_GET1: begin
                ctl.ack1        = 1'b1;
                ctl.rdata1_load = 1'b1;
            end
            default: begin
                ctl.addr_op  = HOLD_ZERO;
                ctl.wdata_op = HOLD_ZERO;
            end
        endcase
    end

endmodule

// ----- rtl/core/two_port_memory_access_arbiter_unit.sv -----
// two_port_memory_access_arbiter_unit: top level of the two-requester memory arbiter
// depends on tpma_pkg and tpma_fsm
// an accepted input beat's result beat is registered in the output register
// one beat per cycle barring m_tready stalls, limited by the single phase register
// reset: synchronous active-low aresetn returns the phase to idle, clears hold registers
// and drops m_tvalid
module two_port_memory_access_arbiter_unit #(
    parameter int ADDR_WIDTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                                   s_tvalid,
    output logic                                                   s_tready,
    // req0, req1, is_write0, is_write1, addr_req0, addr_req1, wdata_req0,
    // wdata_req1, mem_ready, mem_rdata, zero pad
    input  logic [((5 + 2*ADDR_WIDTH + 3*DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,

    output logic                                                   m_tvalid,
    input  logic                                                   m_tready,
    // mem_write, mem_read, ack0, ack1, mem_addr, mem_wdata, rdata0, rdata1, zero pad
    output logic [((4 + ADDR_WIDTH + 3*DATA_WIDTH + 7) / 8) * 8 - 1:0]   m_tdata
);
    import tpma_pkg::*;

    // input beat field offsets
    localparam int A0_LSB  = 4;
    localparam int A1_LSB  = A0_LSB + ADDR_WIDTH;
    localparam int D0_LSB  = A1_LSB + ADDR_WIDTH;
    localparam int D1_LSB  = D0_LSB + DATA_WIDTH;
    localparam int RDY_BIT = D1_LSB + DATA_WIDTH;
    localparam int RD_LSB  = RDY_BIT + 1;

    // output beat field offsets
    localparam int OA_LSB  = 4;
    localparam int OW_LSB  = OA_LSB + ADDR_WIDTH;
    localparam int OR0_LSB = OW_LSB + DATA_WIDTH;
    localparam int OR1_LSB = OR0_LSB + DATA_WIDTH;

    // unpacked input fields
    logic                  req0, req1, is_write0, is_write1, mem_ready;
    logic [ADDR_WIDTH-1:0] addr_req0, addr_req1;
    logic [DATA_WIDTH-1:0] wdata_req0, wdata_req1, mem_rdata;

    assign req0       = s_tdata[0];
    assign req1       = s_tdata[1];
    assign is_write0  = s_tdata[2];
    assign is_write1  = s_tdata[3];
    assign addr_req0  = s_tdata[A0_LSB +: ADDR_WIDTH];
    assign addr_req1  = s_tdata[A1_LSB +: ADDR_WIDTH];
    assign wdata_req0 = s_tdata[D0_LSB +: DATA_WIDTH];
    assign wdata_req1 = s_tdata[D1_LSB +: DATA_WIDTH];
    assign mem_ready  = s_tdata[RDY_BIT];
    assign mem_rdata  = s_tdata[RD_LSB +: DATA_WIDTH];

    // machine state and result registers
    phase_t                phase_reg, phase_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  wr_reg, rd_reg, ack0_reg, ack1_reg;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic [DATA_WIDTH-1:0] wdata_reg, wdata_next;
    logic [DATA_WIDTH-1:0] rdata0_reg, rdata0_next;
    logic [DATA_WIDTH-1:0] rdata1_reg, rdata1_next;

    tpma_ctl_t ctl;
    logic      s_accept;

    // the output register frees up when its beat is taken, so a new input
    // beat can land in the same cycle the previous result leaves
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    tpma_fsm u_fsm (
        .phase      (phase_reg),
        .req0       (req0),
        .req1       (req1),
        .is_write0  (is_write0),
        .is_write1  (is_write1),
        .mem_ready  (mem_ready),
        .phase_next (phase_next),
        .ctl        (ctl)
    );

    // hold register updates selected by the phase reached
    always_comb begin
        case (ctl.addr_op)
            HOLD_ZERO: addr_next = '0;
            HOLD_REQ0: addr_next = addr_req0;
            HOLD_REQ1: addr_next = addr_req1;
            default:   addr_next = addr_reg;
        endcase
        case (ctl.wdata_op)
            HOLD_ZERO: wdata_next = '0;
            HOLD_REQ0: wdata_next = wdata_req0;
            HOLD_REQ1: wdata_next = wdata_req1;
            default:   wdata_next = wdata_reg;
        endcase
        rdata0_next = ctl.rdata0_load ? mem_rdata : rdata0_reg;
        rdata1_next = ctl.rdata1_load ? mem_rdata : rdata1_reg;
    end

    // valid rises on an accepted beat, falls once the result beat is taken
    always_comb begin
        if (s_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // hold registers feed the result beat directly, so they reset to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            m_tvalid_reg <= 1'b0;
            wr_reg       <= 1'b0;
            rd_reg       <= 1'b0;
            ack0_reg     <= 1'b0;
            ack1_reg     <= 1'b0;
            addr_reg     <= '0;
            wdata_reg    <= '0;
            rdata0_reg   <= '0;
            rdata1_reg   <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                phase_reg  <= phase_next;
                wr_reg     <= ctl.mem_write;
                rd_reg     <= ctl.mem_read;
                ack0_reg   <= ctl.ack0;
                ack1_reg   <= ctl.ack1;
                addr_reg   <= addr_next;
                wdata_reg  <= wdata_next;
                rdata0_reg <= rdata0_next;
                rdata1_reg <= rdata1_next;
            end
        end
    end

    // result beat packing, pad bits stay zero
    always_comb begin
        m_tdata                             = '0;
        m_tdata[0]                          = wr_reg;
        m_tdata[1]                          = rd_reg;
        m_tdata[2]                          = ack0_reg;
        m_tdata[3]                          = ack1_reg;
        m_tdata[OA_LSB +: ADDR_WIDTH]       = addr_reg;
        m_tdata[OW_LSB +: DATA_WIDTH]       = wdata_reg;
        m_tdata[OR0_LSB +: DATA_WIDTH]      = rdata0_reg;
        m_tdata[OR1_LSB +: DATA_WIDTH]      = rdata1_reg;
    end

    assign m_tvalid = m_tvalid_reg;

    // phase only moves on an accepted beat
    a_phase_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(phase_reg))
        else $error("phase changed without an accepted beat");

    // a granted requester always gets a strobe on its next beat
    a_dev_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (phase_reg == PH_DEV0 || phase_reg == PH_DEV1))
        |=> (wr_reg || rd_reg))
        else $error("no memory strobe after address phase");

    // acknowledge and memory strobe never share a beat
    a_ack_strobe_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !((ack0_reg || ack1_reg) && (wr_reg || rd_reg)))
        else $error("acknowledge together with a memory strobe");

    // only one requester acknowledged at a time
    a_single_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ack0_reg && ack1_reg))
        else $error("both requesters acknowledged");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for two_port_memory_access_arbiter_unit, one stream beat per tick
// depends on tpma_pkg and the arbiter rtl; result beats are checked mostly against a phase model
module tb;
    import tpma_pkg::*;

    localparam int AW = 16;
    localparam int DW = 32;
    localparam int S_W = ((5 + 2*AW + 3*DW + 7) / 8) * 8;
    localparam int M_W = ((4 + AW + 3*DW + 7) / 8) * 8;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_PER_PHASE = 500;
    localparam int MAX_REPORTS = 10;

    // one tick of both requesters and the memory, last field (req0) in the lowest bits
    typedef struct packed {
        logic [S_W-(5+2*AW+3*DW)-1:0] pad;
        logic [DW-1:0]                mem_rdata;
        logic                         mem_ready;
        logic [DW-1:0]                wdata_req1;
        logic [DW-1:0]                wdata_req0;
        logic [AW-1:0]                addr_req1;
        logic [AW-1:0]                addr_req0;
        logic                         is_write1;
        logic                         is_write0;
        logic                         req1;
        logic                         req0;
    } tick_t;

    typedef struct packed {
        logic [M_W-(4+AW+3*DW)-1:0] pad;
        logic [DW-1:0]              rdata1;
        logic [DW-1:0]              rdata0;
        logic [DW-1:0]              mem_wdata;
        logic [AW-1:0]              mem_addr;
        logic                       ack1;
        logic                       ack0;
        logic                       mem_read;
        logic                       mem_write;
    } result_t;

    typedef struct {
        tick_t   stim;
        bit      typed;
        result_t want;
    } row_t;

    logic           aclk;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    // model of the arbiter
    phase_t         arb_phase  = PH_IDLE;
    logic [AW-1:0]  addr_hold  = '0;
    logic [DW-1:0]  wdata_hold = '0;
    logic [DW-1:0]  rd0_hold   = '0;
    logic [DW-1:0]  rd1_hold   = '0;

    result_t        pending_results[$];
    row_t           directed_rows[$];

    int tx_idle = 0;
    int rx_idle = 0;
    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    int acks_seen = 0;
    int stall_cycles = 0;
    bit req0_on = 0;
    bit req1_on = 0;

    two_port_memory_access_arbiter_unit #(
        .ADDR_WIDTH(AW),
        .DATA_WIDTH(DW)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // next phase from the sampled tick, then outputs of the phase reached
    function automatic result_t predict_tick(tick_t t);
        result_t r;
        phase_t  nxt;
        r = '0;
        case (arb_phase)
            PH_DEV0: nxt = t.is_write0 ? PH_WR0 : PH_RD0;
            PH_WR0:  nxt = t.mem_ready ? PH_END0 : PH_WR0;
            PH_RD0:  nxt = t.mem_ready ? PH_GET0 : PH_RD0;
            PH_END0, PH_GET0: nxt = t.req1 ? PH_DEV1 : PH_IDLE;
            PH_DEV1: nxt = t.is_write1 ? PH_WR1 : PH_RD1;
            PH_WR1:  nxt = t.mem_ready ? PH_END1 : PH_WR1;
            PH_RD1:  nxt = t.mem_ready ? PH_GET1 : PH_RD1;
            PH_END1, PH_GET1: nxt = t.req0 ? PH_DEV0 : PH_IDLE;
            // idle and unused codes: requester 0 wins a tie
            default: nxt = t.req0 ? PH_DEV0 : (t.req1 ? PH_DEV1 : PH_IDLE);
        endcase
        arb_phase = nxt;
        case (nxt)
            PH_DEV0: begin
                wdata_hold = '0;
                addr_hold  = t.addr_req0;
            end
            PH_WR0: begin
                r.mem_write = 1'b1;
                wdata_hold  = t.wdata_req0;
            end
            PH_END0: r.ack0 = 1'b1;
            PH_RD0:  r.mem_read = 1'b1;
            PH_GET0: begin
                r.ack0   = 1'b1;
                rd0_hold = t.mem_rdata;
            end
            PH_DEV1: begin
                wdata_hold = '0;
                addr_hold  = t.addr_req1;
            end
            PH_WR1: begin
                r.mem_write = 1'b1;
                wdata_hold  = t.wdata_req1;
            end
            // write end of requester 1 acks like requester 0, no read strobe
            PH_END1: r.ack1 = 1'b1;
            PH_RD1:  r.mem_read = 1'b1;
            PH_GET1: begin
                r.ack1   = 1'b1;
                rd1_hold = t.mem_rdata;
            end
            default: begin
                addr_hold  = '0;
                wdata_hold = '0;
            end
        endcase
        r.mem_addr  = addr_hold;
        r.mem_wdata = wdata_hold;
        r.rdata0    = rd0_hold;
        r.rdata1    = rd1_hold;
        return r;
    endfunction

    function automatic tick_t tick(logic r0, logic r1, logic w0, logic w1,
                                   logic [AW-1:0] a0, logic [AW-1:0] a1,
                                   logic [DW-1:0] d0, logic [DW-1:0] d1,
                                   logic rdy, logic [DW-1:0] rd);
        tick_t t;
        t = '0;
        t.req0 = r0;
        t.req1 = r1;
        t.is_write0 = w0;
        t.is_write1 = w1;
        t.addr_req0 = a0;
        t.addr_req1 = a1;
        t.wdata_req0 = d0;
        t.wdata_req1 = d1;
        t.mem_ready = rdy;
        t.mem_rdata = rd;
        return t;
    endfunction

    function automatic result_t res(logic wr, logic rs, logic k0, logic k1,
                                    logic [AW-1:0] a, logic [DW-1:0] d,
                                    logic [DW-1:0] q0, logic [DW-1:0] q1);
        result_t r;
        r = '0;
        r.mem_write = wr;
        r.mem_read = rs;
        r.ack0 = k0;
        r.ack1 = k1;
        r.mem_addr = a;
        r.mem_wdata = d;
        r.rdata0 = q0;
        r.rdata1 = q1;
        return r;
    endfunction

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // mostly random words, sometimes all zeros or all ones
    function automatic logic [DW-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    // requesters hold their select for a while, as a real master would
    function automatic tick_t random_tick();
        tick_t t;
        t = '0;
        req0_on = req0_on ? chance(88) : chance(35);
        req1_on = req1_on ? chance(88) : chance(35);
        if (chance(10)) begin
            req0_on = chance(50);
            req1_on = chance(50);
        end
        t.req0 = req0_on;
        t.req1 = req1_on;
        t.is_write0 = chance(50);
        t.is_write1 = chance(50);
        t.addr_req0 = AW'(pick_word());
        t.addr_req1 = AW'(pick_word());
        t.wdata_req0 = pick_word();
        t.wdata_req1 = pick_word();
        t.mem_ready = chance(40);
        t.mem_rdata = pick_word();
        return t;
    endfunction

    // one input beat: random gap, then hold valid until the handshake
    task automatic send_tick(input tick_t t, input bit typed, input result_t want);
        result_t guess;
        while ($urandom_range(0, 99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do @(posedge aclk); while (!s_tready);
        guess = predict_tick(t);
        pending_results.push_back(typed ? want : guess);
        beats_in++;
    endtask

    task automatic check_field(input string name, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s at beat %0d: expected %h, got %h",
                         name, beats_out, want, got);
        end
    endtask

    // result side: compare every accepted beat, then draw the next tready
    always @(posedge aclk) begin : result_monitor
        result_t got;
        result_t want;
        if (m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result beat %h with nothing expected", got);
            end else begin
                want = pending_results.pop_front();
                check_field("mem_write", DW'(want.mem_write), DW'(got.mem_write));
                check_field("mem_read", DW'(want.mem_read), DW'(got.mem_read));
                check_field("ack0", DW'(want.ack0), DW'(got.ack0));
                check_field("ack1", DW'(want.ack1), DW'(got.ack1));
                check_field("mem_addr", DW'(want.mem_addr), DW'(got.mem_addr));
                check_field("mem_wdata", want.mem_wdata, got.mem_wdata);
                check_field("rdata0", want.rdata0, got.rdata0);
                check_field("rdata1", want.rdata1, got.rdata1);
            end
            beats_out++;
            acks_seen += int'(got.ack0) + int'(got.ack1);
        end
        stall_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ?
                        0 : stall_cycles + 1;
        m_tready <= ($urandom_range(0, 99) >= rx_idle);
    end

    // watchdog on cycles without any handshake
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("tb failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle = 34;
        rx_idle = 56;

        // directed walk through every phase; only the opening rows are typed in
        directed_rows.push_back('{tick(0, 0, 0, 0, '0, '0, '0, '0, 0, '0), 1,
                                  res(0, 0, 0, 0, '0, '0, '0, '0)});
        directed_rows.push_back('{tick(1, 0, 1, 0, '1, '0, '0, '0, 0, '0), 1,
                                  res(0, 0, 0, 0, '1, '0, '0, '0)});
        directed_rows.push_back('{tick(1, 0, 1, 0, '0, '0, '1, '0, 0, '0), 1,
                                  res(1, 0, 0, 0, '1, '1, '0, '0)});
        directed_rows.push_back('{tick(1, 0, 1, 0, '0, '0, '1, '0, 1, '0), 1,
                                  res(0, 0, 1, 0, '1, '1, '0, '0)});
        // hand over to requester 1 for a read
        directed_rows.push_back('{tick(1, 1, 0, 0, '1, '0, '0, '0, 0, '0), 0, '0});
        directed_rows.push_back('{tick(0, 1, 0, 0, '0, '1, '0, '0, 0, '1), 0, '0});
        directed_rows.push_back('{tick(0, 1, 0, 0, '0, '0, '0, '0, 1, '1), 0, '0});
        // back to requester 0 for a read with a stall
        directed_rows.push_back('{tick(1, 1, 0, 1, 16'h1234, '1, '0, '0, 0, '0), 0, '0});
        directed_rows.push_back('{tick(1, 1, 0, 1, '0, '0, '0, '0, 0, '0), 0, '0});
        directed_rows.push_back('{tick(1, 1, 0, 1, '0, '0, '0, '0, 0, 32'hdeadbeef), 0, '0});
        directed_rows.push_back('{tick(1, 1, 0, 1, '0, '0, '0, '0, 1, '1), 0, '0});
        // requester 1 write, its end acks without a read strobe
        directed_rows.push_back('{tick(0, 1, 0, 1, '0, '1, '0, '0, 0, '0), 0, '0});
        directed_rows.push_back('{tick(0, 1, 0, 1, '0, '0, '0, '1, 0, '0), 0, '0});
        directed_rows.push_back('{tick(0, 1, 0, 1, '0, '0, '0, 32'h5a5a5a5a, 0, '0), 0, '0});
        directed_rows.push_back('{tick(0, 1, 0, 1, '0, '0, '0, '1, 1, '0), 0, '0});
        directed_rows.push_back('{tick(0, 0, 0, 0, '1, '1, '1, '1, 0, '1), 0, '0});
        // both ask from idle
        directed_rows.push_back('{tick(1, 1, 1, 1, 16'haaaa, 16'h5555, '1, '1, 1, '0), 0, '0});
        directed_rows.push_back('{tick(1, 1, 1, 1, '0, '0, '0, '1, 1, '0), 0, '0});
        directed_rows.push_back('{tick(0, 0, 0, 0, '0, '0, '0, '0, 1, '0), 0, '0});
        directed_rows.push_back('{tick(0, 0, 0, 0, '0, '0, '0, '0, 0, '0), 0, '0});
        // only requester 1 asks from idle
        directed_rows.push_back('{tick(0, 1, 0, 1, '0, 16'h00ff, '0, '0, 0, '0), 0, '0});
        directed_rows.push_back('{tick(0, 1, 0, 1, '0, '0, '0, 32'h80000001, 0, '0), 0, '0});
        directed_rows.push_back('{tick(1, 1, 0, 1, '0, '0, '0, '0, 1, '0), 0, '0});
        directed_rows.push_back('{tick(1, 0, 0, 0, 16'h8001, '0, '0, '0, 0, '0), 0, '0});

        foreach (directed_rows[i])
            send_tick(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 34 : (ph == 1) ? 56 : 0;
            rx_idle = (ph == 0) ? 56 : (ph == 1) ? 34 : 0;
            repeat (RANDOM_PER_PHASE)
                send_tick(random_tick(), 0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d tick beats sent, %0d result beats checked, %0d acks seen",
                 beats_in, beats_out, acks_seen);
        $display("all phases visited under three idling mixes, %0d mismatches", mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
